// ===== rtl/core/fea_pkg.sv =====
// Package with the constants, types and angle table of the flat-earth azimuth pipeline.
package fea_pkg;

  // Input angle format and CORDIC depth.
  localparam int ANGLE_FRACTION_BITS = 20;
  localparam int CORDIC_STAGES       = 24;
  localparam int CORDIC_ITERS        = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

  // Internal angles carry 24 fraction bits.
  localparam int TBITS    = 24;
  localparam int LAT_SHIFT = TBITS - ANGLE_FRACTION_BITS;
  localparam int MSUM_W   = 45;

  localparam logic signed [31:0] DEG90       = 32'sd1509949440;
  localparam logic [34:0]        DEG90_U     = 35'd1509949440;
  localparam logic [34:0]        DEG180_U    = 35'd3019898880;
  localparam logic [34:0]        DEG270_U    = 35'd4529848320;
  localparam logic [34:0]        DEG360_U    = 35'd6039797760;
  localparam logic [24:0]        OUT_DEG360  = 25'd23592960;
  localparam logic signed [33:0] COS_INV_GAIN = 34'sd652032874;
  localparam logic signed [33:0] COS_ONE      = 34'sd1073741824;
  localparam logic signed [23:0] KE_Q16       = 24'sd7302234;
  localparam logic signed [23:0] KN0_Q16      = 24'sd7226312;
  localparam logic signed [27:0] KN1_Q32      = 28'sd80162988;

  // Sign and zero flags of the two offsets.
  typedef struct packed {
    logic e_zero;
    logic e_neg;
    logic n_neg;
    logic n_pos;
    logic ay_zero;
  } quad_t;

  // Arctangent of 2^-i in degrees with 24 fraction bits.
  function automatic logic [29:0] atan_deg(input logic [4:0] i);
    logic [29:0] r;
    unique case (i)
      5'd0:  r = 30'd754974720;
      5'd1:  r = 30'd445687602;
      5'd2:  r = 30'd235489088;
      5'd3:  r = 30'd119537938;
      5'd4:  r = 30'd60000934;
      5'd5:  r = 30'd30029717;
      5'd6:  r = 30'd15018523;
      5'd7:  r = 30'd7509720;
      5'd8:  r = 30'd3754917;
      5'd9:  r = 30'd1877466;
      5'd10: r = 30'd938734;
      5'd11: r = 30'd469367;
      5'd12: r = 30'd234684;
      5'd13: r = 30'd117342;
      5'd14: r = 30'd58671;
      5'd15: r = 30'd29335;
      5'd16: r = 30'd14668;
      5'd17: r = 30'd7334;
      5'd18: r = 30'd3667;
      5'd19: r = 30'd1833;
      5'd20: r = 30'd917;
      5'd21: r = 30'd458;
      5'd22: r = 30'd229;
      5'd23: r = 30'd115;
      5'd24: r = 30'd57;
      5'd25: r = 30'd29;
      5'd26: r = 30'd14;
      5'd27: r = 30'd7;
      5'd28: r = 30'd4;
      5'd29: r = 30'd2;
      5'd30: r = 30'd1;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/flat_earth_azimuth_top.sv =====
// Top level of the flat-earth azimuth pipeline.
// Stage order: 1, 2, cosine CORDIC, M1, M2, P, arctangent CORDIC, registered final stage.
// Throughput: one word per cycle; each cosine and arctangent CORDIC iteration is its own stage.
// The whole pipeline advances together; it holds only when the output word is stalled.
// Reset (rst, synchronous, active high) clears all valid bits; data registers are not reset.
module flat_earth_azimuth_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [28:0] origin_longitude,
  input  logic [28:0] dest_longitude,
  input  logic [27:0] dest_latitude,
  input  logic [27:0] origin_latitude,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [24:0] azimuth
);

  localparam int N = fea_pkg::CORDIC_ITERS;

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Stage 1: differences and clamped mean latitude.
  logic                          v1;
  logic signed [29:0]            s1_dlon;
  logic signed [28:0]            s1_dlat;
  logic signed [31:0]            s1_mean;
  logic signed [fea_pkg::MSUM_W-1:0] msum;
  logic signed [fea_pkg::MSUM_W-1:0] mhalf;
  logic signed [31:0]            mean_next;

  always_comb begin
    msum  = fea_pkg::MSUM_W'($signed(origin_latitude)) +
            fea_pkg::MSUM_W'($signed(dest_latitude));
    mhalf = (msum <<< fea_pkg::LAT_SHIFT) >>> 1;
    if (mhalf > fea_pkg::MSUM_W'(fea_pkg::DEG90)) begin
      mean_next = fea_pkg::DEG90;
    end else if (mhalf < -fea_pkg::MSUM_W'(fea_pkg::DEG90)) begin
      mean_next = -fea_pkg::DEG90;
    end else begin
      mean_next = mhalf[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
    if (adv) begin
      s1_dlon <= 30'($signed(origin_longitude)) - 30'($signed(dest_longitude));
      s1_dlat <= 29'($signed(dest_latitude)) - 29'($signed(origin_latitude));
      s1_mean <= mean_next;
    end
  end

  // Stage 2: latitude slope product for the north scale.
  logic               v2;
  logic signed [59:0] s2_prodn;
  logic signed [31:0] s2_mean;
  logic signed [29:0] s2_dlon;
  logic signed [28:0] s2_dlat;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      s2_prodn <= s1_mean * fea_pkg::KN1_Q32;
      s2_mean  <= s1_mean;
      s2_dlon  <= s1_dlon;
      s2_dlat  <= s1_dlat;
    end
  end

  // Cosine CORDIC in rotation mode, one iteration per stage.
  logic               cv    [0:N];
  logic signed [33:0] cx    [0:N];
  logic signed [33:0] cy    [0:N];
  logic signed [33:0] cz    [0:N];
  logic signed [29:0] cdlon [0:N];
  logic signed [28:0] cdlat [0:N];
  logic signed [23:0] cnf   [0:N];

  always_comb begin
    cv[0]    = v2;
    cx[0]    = fea_pkg::COS_INV_GAIN;
    cy[0]    = '0;
    cz[0]    = 34'(s2_mean);
    cdlon[0] = s2_dlon;
    cdlat[0] = s2_dlat;
    cnf[0]   = fea_pkg::KN0_Q16 + 24'($signed(s2_prodn[59:40]));
  end

  for (genvar k = 0; k < N; k++) begin : g_cos
    logic signed [33:0] ang;
    assign ang = $signed({4'b0, fea_pkg::atan_deg(5'(k))});

    always_ff @(posedge clk) begin
      if (rst) begin
        cv[k+1] <= 1'b0;
      end else if (adv) begin
        cv[k+1] <= cv[k];
      end
      if (adv) begin
        if (cz[k] >= 0) begin
          cx[k+1] <= cx[k] - (cy[k] >>> k);
          cy[k+1] <= cy[k] + (cx[k] >>> k);
          cz[k+1] <= cz[k] - ang;
        end else begin
          cx[k+1] <= cx[k] + (cy[k] >>> k);
          cy[k+1] <= cy[k] - (cx[k] >>> k);
          cz[k+1] <= cz[k] + ang;
        end
        cdlon[k+1] <= cdlon[k];
        cdlat[k+1] <= cdlat[k];
        cnf[k+1]   <= cnf[k];
      end
    end
  end

  // Clamp the cosine to [0, 1].
  logic [30:0] cosv;
  always_comb begin
    if (cx[N] < 0) begin
      cosv = '0;
    end else if (cx[N] > fea_pkg::COS_ONE) begin
      cosv = 31'(fea_pkg::COS_ONE);
    end else begin
      cosv = cx[N][30:0];
    end
  end

  // Stage M1: longitude times cosine, latitude difference times north scale.
  logic               vm1;
  logic signed [61:0] m1_pe;
  logic signed [52:0] m1_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm1 <= 1'b0;
    end else if (adv) begin
      vm1 <= cv[N];
    end
    if (adv) begin
      m1_pe <= cdlon[N] * $signed({1'b0, cosv});
      m1_n  <= cdlat[N] * cnf[N];
    end
  end

  // Stage M2: east offset scaled by the longitude degree length.
  logic               vm2;
  logic signed [55:0] m2_e;
  logic signed [52:0] m2_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm2 <= 1'b0;
    end else if (adv) begin
      vm2 <= vm1;
    end
    if (adv) begin
      m2_e <= $signed(m1_pe[61:30]) * fea_pkg::KE_Q16;
      m2_n <= m1_n;
    end
  end

  // Stage P: magnitudes and quadrant flags.
  logic               vp;
  logic signed [55:0] p_ax;
  logic signed [55:0] p_ay;
  fea_pkg::quad_t     p_q;
  logic signed [55:0] n_ext;

  assign n_ext = 56'(m2_n);

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
    end else if (adv) begin
      vp <= vm2;
    end
    if (adv) begin
      p_ax          <= (m2_e < 0) ? -m2_e : m2_e;
      p_ay          <= (n_ext < 0) ? -n_ext : n_ext;
      p_q.e_zero    <= (m2_e == 0);
      p_q.e_neg     <= (m2_e < 0);
      p_q.n_neg     <= (m2_n < 0);
      p_q.n_pos     <= (m2_n > 0);
      p_q.ay_zero   <= (m2_n == 0);
    end
  end

  // Arctangent CORDIC in vectoring mode, one iteration per stage.
  logic               av [0:N];
  logic signed [55:0] ax [0:N];
  logic signed [55:0] ay [0:N];
  logic signed [31:0] az [0:N];
  fea_pkg::quad_t     aq [0:N];

  always_comb begin
    av[0] = vp;
    ax[0] = p_ax;
    ay[0] = p_ay;
    az[0] = '0;
    aq[0] = p_q;
  end

  for (genvar k = 0; k < N; k++) begin : g_atan
    logic signed [31:0] ang;
    assign ang = $signed({2'b0, fea_pkg::atan_deg(5'(k))});

    always_ff @(posedge clk) begin
      if (rst) begin
        av[k+1] <= 1'b0;
      end else if (adv) begin
        av[k+1] <= av[k];
      end
      if (adv) begin
        if (ay[k] > 0) begin
          ax[k+1] <= ax[k] + (ay[k] >>> k);
          ay[k+1] <= ay[k] - (ax[k] >>> k);
          az[k+1] <= az[k] + ang;
        end else begin
          ax[k+1] <= ax[k] - (ay[k] >>> k);
          ay[k+1] <= ay[k] + (ax[k] >>> k);
          az[k+1] <= az[k] - ang;
        end
        aq[k+1] <= aq[k];
      end
    end
  end

  // Final stage: quadrant mapping, wrap and rounding to 16 fraction bits.
  logic [34:0] phi;
  logic [34:0] bear;
  logic [34:0] bwrap;
  logic [26:0] rnd;
  logic [24:0] az_next;

  always_comb begin
    if (aq[N].ay_zero || az[N] < 0) begin
      phi = '0;
    end else if (az[N] > fea_pkg::DEG90) begin
      phi = fea_pkg::DEG90_U;
    end else begin
      phi = 35'(az[N]);
    end
    if (aq[N].e_zero) begin
      if (aq[N].n_pos) begin
        bear = '0;
      end else if (aq[N].n_neg) begin
        bear = fea_pkg::DEG180_U;
      end else begin
        bear = fea_pkg::DEG90_U;
      end
    end else if (!aq[N].e_neg) begin
      bear = aq[N].n_neg ? fea_pkg::DEG90_U + phi : fea_pkg::DEG90_U - phi;
    end else begin
      bear = aq[N].n_neg ? fea_pkg::DEG270_U - phi : fea_pkg::DEG270_U + phi;
    end
    bwrap = (bear >= fea_pkg::DEG360_U) ? bear - fea_pkg::DEG360_U : bear;
    rnd   = 27'((bwrap + 35'd128) >> 8);
    az_next = (rnd >= 27'(fea_pkg::OUT_DEG360)) ? '0 : rnd[24:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= av[N];
    end
    if (adv) begin
      azimuth <= az_next;
    end
  end

endmodule

// ===== rtl/core/fea_checker.sv =====
// Port-level checker for the flat-earth azimuth pipeline, bound to the top level.
module fea_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [24:0] azimuth
);

  // The output word is always below one full turn.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (azimuth < fea_pkg::OUT_DEG360))
    else $error("azimuth out of range");

  // The input side holds only while the output word is stalled.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output stall");

  // A stalled input word stays offered until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_stall) |=> in_valid)
    else $error("stalled input word withdrawn");

  // Reset empties the pipeline.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // A stalled output word stays and keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(azimuth)))
    else $error("stalled output word changed");

endmodule

bind flat_earth_azimuth_top fea_checker u_fea_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .azimuth   (azimuth)
);

// ===== dv/tb_flat_earth_azimuth_top.sv =====
// Self-checking testbench for the flat-earth azimuth pipeline.
module tb_flat_earth_azimuth_top;

  typedef struct packed {
    logic [28:0] olon;
    logic [28:0] dlon;
    logic [27:0] dlat;
    logic [27:0] olat;
  } coord_word_t;

  localparam int LATENCY = 2 * fea_pkg::CORDIC_ITERS + 6;
  localparam logic signed [27:0] LAT_MAX = 28'sd94371840;
  localparam logic signed [28:0] LON_MAX = 29'sd188743680;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [28:0] origin_longitude = '0;
  logic [28:0] dest_longitude = '0;
  logic [27:0] dest_latitude = '0;
  logic [27:0] origin_latitude = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [24:0] azimuth;

  coord_word_t pending_words[$];
  logic [24:0] expected_azimuths[$];
  int error_count = 0;
  int word_count = 0;
  int result_count = 0;
  int send_idle_pct = 28;
  int recv_idle_pct = 80;
  int hold_off_cycles = 0;
  bit drain_pause = 1'b0;

  flat_earth_azimuth_top dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .origin_longitude(origin_longitude), .dest_longitude(dest_longitude),
    .dest_latitude(dest_latitude), .origin_latitude(origin_latitude),
    .out_valid(out_valid), .out_stall(out_stall), .azimuth(azimuth)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Arithmetic shift right with floor, on 64-bit values.
  function automatic longint floor_shift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint atan_table(int i);
    longint t[32] = '{754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
                      15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
                      117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229,
                      115, 57, 29, 14, 7, 4, 2, 1, 0};
    return t[i];
  endfunction

  // Cosine of an angle in degrees (Q24), Q2.30 result, clamped to [0, 1].
  function automatic longint cos_of_lat(longint ang);
    longint x, y, dx, dy;
    x = 652032874;
    y = 0;
    for (int i = 0; i < fea_pkg::CORDIC_ITERS; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (ang >= 0) begin
        x -= dx; y += dy; ang -= longint'(atan_table(i));
      end else begin
        x += dx; y -= dy; ang += longint'(atan_table(i));
      end
    end
    if (x < 0) x = 0;
    if (x > 64'sd1073741824) x = 64'sd1073741824;
    return x;
  endfunction

  // Angle of (x, y) in the first quadrant, degrees Q24, clamped to [0, 90].
  function automatic longint first_quadrant_angle(longint x, longint y);
    longint ang, dx, dy;
    ang = 0;
    for (int i = 0; i < fea_pkg::CORDIC_ITERS; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (y > 0) begin
        x += dx; y -= dy; ang += atan_table(i);
      end else begin
        x -= dx; y += dy; ang -= atan_table(i);
      end
    end
    if (ang < 0) ang = 0;
    if (ang > 64'sd1509949440) ang = 64'sd1509949440;
    return ang;
  endfunction

  // Bearing from origin to destination in degrees Q16.
  function automatic logic [24:0] bearing_of(coord_word_t w);
    longint lo, ld, latd, lato, mean, cosv, e, n, nf, phi, az, r;
    longint d90, d360;
    d90 = longint'(90) <<< 24;
    d360 = longint'(360) <<< 24;
    lo = longint'(signed'(w.olon));
    ld = longint'(signed'(w.dlon));
    latd = longint'(signed'(w.dlat));
    lato = longint'(signed'(w.olat));
    mean = floor_shift((lato + latd) * (longint'(1) <<< fea_pkg::LAT_SHIFT), 1);
    if (mean > d90) mean = d90;
    if (mean < -d90) mean = -d90;
    cosv = cos_of_lat(mean);
    e = floor_shift((lo - ld) * cosv, 30) * 7302234;
    nf = 7226312 + floor_shift(mean * 80162988, 40);
    n = (latd - lato) * nf;
    if (e == 0) begin
      if (n > 0) az = 0;
      else if (n < 0) az = 2 * d90;
      else az = d90;
    end else begin
      phi = (n == 0) ? 0 : first_quadrant_angle(e < 0 ? -e : e, n < 0 ? -n : n);
      if (e > 0) az = (n >= 0) ? d90 - phi : d90 + phi;
      else az = (n < 0) ? 3 * d90 - phi : 3 * d90 + phi;
    end
    if (az < 0) az += d360;
    if (az >= d360) az -= d360;
    r = (az + (longint'(1) <<< 7)) >>> 8;
    if (r >= (longint'(360) <<< 16)) r -= longint'(360) <<< 16;
    return r[24:0];
  endfunction

  task automatic report_mismatch(string what);
    error_count++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  task automatic add_word(longint olon, longint dlon, longint dlat, longint olat);
    coord_word_t w;
    w.olon = olon[28:0];
    w.dlon = dlon[28:0];
    w.dlat = dlat[27:0];
    w.olat = olat[27:0];
    pending_words.push_back(w);
  endtask

  function automatic longint rand_lon();
    return longint'($urandom_range(377487360)) - 188743680;
  endfunction

  function automatic longint rand_lat();
    return longint'($urandom_range(188743680)) - 94371840;
  endfunction

  // Driver: offers the next pending word, holding it while stalled.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_azimuths.push_back(bearing_of({origin_longitude, dest_longitude,
                                                dest_latitude, origin_latitude}));
        word_count++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_words.size() > 0 && !drain_pause &&
            $urandom_range(99) >= send_idle_pct) begin
          coord_word_t w;
          w = pending_words.pop_front();
          in_valid <= 1'b1;
          origin_longitude <= w.olon;
          dest_longitude <= w.dlon;
          dest_latitude <= w.dlat;
          origin_latitude <= w.olat;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall: random, or held off for a counted stretch.
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor: checks each accepted result word against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      result_count++;
      if (expected_azimuths.size() == 0) begin
        report_mismatch($sformatf("unexpected azimuth %0d", azimuth));
      end else begin
        logic [24:0] exp_az;
        exp_az = expected_azimuths.pop_front();
        if (azimuth !== exp_az)
          report_mismatch($sformatf("azimuth %0d, expected %0d", azimuth, exp_az));
      end
    end
  end

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_valid || expected_azimuths.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed words: extremes, compass points, clamped latitudes, out-of-range inputs.
    add_word(0, 0, 0, 0);
    add_word(0, 0, 1000000, 0);
    add_word(0, 0, -1000000, 0);
    add_word(1000000, 0, 0, 0);
    add_word(-1000000, 0, 0, 0);
    add_word(1000000, 0, 1000000, 0);
    add_word(1000000, 0, -1000000, 0);
    add_word(-1000000, 0, -1000000, 0);
    add_word(-1000000, 0, 1000000, 0);
    add_word(LON_MAX, -LON_MAX, LAT_MAX, -LAT_MAX);
    add_word(-LON_MAX, LON_MAX, -LAT_MAX, LAT_MAX);
    add_word(LON_MAX, 0, LAT_MAX, LAT_MAX);
    add_word(5, 0, -LAT_MAX, -LAT_MAX);
    add_word(-268435456, 268435455, 134217727, -134217728);
    add_word(268435455, -268435456, -134217728, 134217727);
    add_word(100, 0, 134217727, 134217727);
    add_word(1, 0, 0, 0);
    add_word(0, 0, 1, 0);
    add_word(1, 0, 1, 0);
    add_word(-1, 0, -1, 0);
    add_word(0, 1, 0, -1);
    add_word(1000, 0, 1, 0);
    add_word(1, 0, 100000000, -100000000);

    // Phase one, then a pause until everything drains.
    for (int i = 0; i < 200; i++) begin
      int kind;
      longint olon, olat;
      kind = $urandom_range(9);
      olon = rand_lon();
      olat = rand_lat();
      if (kind < 5)
        add_word(olon, olon + longint'($urandom_range(4000000)) - 2000000,
                 olat + longint'($urandom_range(4000000)) - 2000000, olat);
      else if (kind < 8)
        add_word(olon, rand_lon(), rand_lat(), olat);
      else
        add_word($urandom, $urandom, $urandom, $urandom);
    end
    wait (pending_words.size() == 0);
    drain_pause = 1'b1;
    wait_drained();
    drain_pause = 1'b0;

    // Long receiver hold-off so the pipeline fills and stalls its input.
    send_idle_pct = 0;
    @(posedge clk);
    hold_off_cycles <= 3 * LATENCY;
    for (int i = 0; i < 120; i++) add_word(rand_lon(), rand_lon(), rand_lat(), rand_lat());
    wait_drained();

    send_idle_pct = 80;
    recv_idle_pct = 28;
    for (int i = 0; i < 160; i++) begin
      longint olon, olat;
      olon = rand_lon();
      olat = rand_lat();
      add_word(olon, olon + longint'($urandom_range(200)) - 100,
               olat + longint'($urandom_range(200)) - 100, olat);
    end
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 150; i++) add_word(rand_lon(), rand_lon(), rand_lat(), rand_lat());
    wait_drained();

    repeat (LATENCY + 10) @(posedge clk);
    $display("Checked %0d bearings from %0d coordinate words across idle mixes,",
             result_count, word_count);
    $display("including compass points, clamped latitudes and a full-pipeline hold-off.");
    if (error_count == 0 && expected_azimuths.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d results outstanding.", expected_azimuths.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
